[hdl/acp_pkg.sv]
// Shared types, constants and lookup functions for the AT command line parser.
package acp_pkg;

  localparam int unsigned NAME_CNT_W   = 5;
  localparam int unsigned NAME_CNT_SAT = 31;
  localparam int unsigned ARG_W        = 9;
  localparam int unsigned LINE_MAX     = 512;
  localparam int unsigned ARG_CAP      = ((LINE_MAX - 1) < 511) ? (LINE_MAX - 1) : 511;
  localparam int unsigned PASS_LEN     = 11;
  localparam int unsigned PASS_W       = 4;
  localparam int unsigned CLEN_W       = 4;

  typedef enum logic [2:0] {
    CMD_ERASE,
    CMD_WRITE,
    CMD_UPDATE,
    CMD_RST,
    CMD_LOGIN,
    CMD_RUN_APP,
    CMD_RUN_BOOT,
    CMD_CRC
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FAIL,
    ST_LOGIN_REQ,
    ST_UNSUPPORTED
  } status_e;

  typedef enum logic [2:0] {
    RG_ALL,
    RG_APP,
    RG_SWAP,
    RG_DATA,
    RG_NONE
  } region_e;

  typedef struct packed {
    logic done;
    logic hit;
    cmd_e cmd;
  } match_t;

  function automatic logic [CLEN_W-1:0] cmd_len(cmd_e k);
    logic [CLEN_W-1:0] len;
    case (k)
      CMD_ERASE:    len = 4'd5;
      CMD_WRITE:    len = 4'd5;
      CMD_UPDATE:   len = 4'd6;
      CMD_RST:      len = 4'd3;
      CMD_LOGIN:    len = 4'd5;
      CMD_RUN_APP:  len = 4'd9;
      CMD_RUN_BOOT: len = 4'd10;
      CMD_CRC:      len = 4'd3;
      default:      len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic cmd_needs_login(cmd_e k);
    return (k == CMD_ERASE) || (k == CMD_WRITE) || (k == CMD_UPDATE);
  endfunction

  // Character j of command k; names are right-justified in an 80-bit word.
  function automatic logic [7:0] cmd_char(cmd_e k, logic [CLEN_W-1:0] j);
    logic [79:0]       s;
    logic [CLEN_W-1:0] idx;
    case (k)
      CMD_ERASE:    s = 80'("ERASE");
      CMD_WRITE:    s = 80'("WRITE");
      CMD_UPDATE:   s = 80'("UPDATE");
      CMD_RST:      s = 80'("RST");
      CMD_LOGIN:    s = 80'("LOGIN");
      CMD_RUN_APP:  s = 80'({"START_", "APP"});
      CMD_RUN_BOOT: s = 80'({"START_", "BOOT"});
      CMD_CRC:      s = 80'("CRC");
      default:      s = '0;
    endcase
    idx = cmd_len(k) - 4'd1 - j;
    return s[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] pass_char(logic [PASS_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = "=";
      4'd1:    c = "\"";
      4'd2:    c = "e";
      4'd3:    c = "e";
      4'd4:    c = "X";
      4'd5:    c = "c";
      4'd6:    c = "l";
      4'd7:    c = "o";
      4'd8:    c = "u";
      4'd9:    c = "d";
      4'd10:   c = "\"";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic region_e region_of(logic [7:0] c);
    region_e r;
    case (c)
      "A", "a": r = RG_APP;
      "S", "s": r = RG_SWAP;
      "D", "d": r = RG_DATA;
      default:  r = RG_NONE;
    endcase
    return r;
  endfunction

endpackage

[hdl/acp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module acp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/acp_matcher.sv]
// Sequencer that walks the command table with one shared byte comparator.
module acp_matcher
  import acp_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  ack_i,
  input  logic [NAME_CNT_W-1:0] name_count_i,
  input  logic [7:0]            rdata_i,
  output logic [AW-1:0]         raddr_o,
  output match_t                match_o
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LEN,
    M_FETCH,
    M_CMP,
    M_DONE
  } mstate_e;

  mstate_e           state_q, state_d;
  cmd_e              k_q, k_d;
  logic [CLEN_W-1:0] j_q, j_d;
  logic              hit_q, hit_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    hit_d   = hit_q;
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          k_d     = CMD_ERASE;
          state_d = M_LEN;
        end
      end
      M_LEN: begin
        if (name_count_i == {1'b0, cmd_len(k_q)}) begin
          j_d     = '0;
          state_d = M_FETCH;
        end else if (k_q == CMD_CRC) begin
          hit_d   = 1'b0;
          state_d = M_DONE;
        end else begin
          k_d     = cmd_e'(k_q + 3'd1);
          state_d = M_LEN;
        end
      end
      M_FETCH: begin
        state_d = M_CMP;
      end
      M_CMP: begin
        if (rdata_i == cmd_char(k_q, j_q)) begin
          if (j_q == cmd_len(k_q) - 4'd1) begin
            hit_d   = 1'b1;
            state_d = M_DONE;
          end else begin
            j_d     = j_q + 4'd1;
            state_d = M_FETCH;
          end
        end else if (k_q == CMD_CRC) begin
          hit_d   = 1'b0;
          state_d = M_DONE;
        end else begin
          k_d     = cmd_e'(k_q + 3'd1);
          state_d = M_LEN;
        end
      end
      M_DONE: begin
        if (ack_i) begin
          state_d = M_IDLE;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      k_q     <= CMD_ERASE;
      j_q     <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      hit_q   <= hit_d;
    end
  end

  assign raddr_o = AW'(j_q);
  assign match_o = '{done: (state_q == M_DONE), hit: hit_q, cmd: k_q};

endmodule

[hdl/at_command_line_parser.sv]
// AT command line parser top level: byte front end, name store, matcher and result register.
//
// Bytes enter one per cycle on the slave stream while a line is being scanned; the
// A, T, '+' prefix, the upper-cased command name, the argument count and the password
// scan all update in the cycle a word is taken. A CR or LF that ends a line drops tready
// while the sequencer compares the stored name against the command table with its single
// byte comparator, checking the length of each table entry in turn and, where it fits,
// fetching and comparing its characters one by one; the sequencer then hands the result
// to the output register. If the previous result word still waits in the output
// register, tready stays low until that word is taken; otherwise bytes are taken again
// while the new word waits, up to the next line end.
module at_command_line_parser
  import acp_pkg::*;
#(
  parameter int unsigned NAME_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // status, command, erase_region, login_state,
                                        // arg_length, zero pad
);

  localparam int unsigned AW = $clog2(NAME_MAX);

  typedef enum logic [2:0] {
    PH_WAIT_A,
    PH_WAIT_T,
    PH_WAIT_PLUS,
    PH_GATHER,
    PH_MATCH
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [NAME_CNT_W-1:0] name_count_q, name_count_d;
  logic                  name_closed_q, name_closed_d;
  logic [ARG_W-1:0]      arg_count_q, arg_count_d;
  logic [7:0]            arg_second_q, arg_second_d;
  logic                  logged_in_q, logged_in_d;
  logic [PASS_W-1:0]     pass_stage_q, pass_stage_d;
  logic                  pass_found_q, pass_found_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  cmd_e                  command_q, command_d;
  region_e               region_q, region_d;
  logic [ARG_W-1:0]      alen_q, alen_d;

  logic                  s_acc;
  logic                  commit;
  logic                  start;
  logic                  name_we;
  logic [7:0]            rx_b;
  logic [7:0]            rx_up;
  logic [7:0]            rdata;
  logic [AW-1:0]         raddr;
  logic [ARG_W:0]        alen_sum;
  match_t                match;

  assign rx_b            = s_axis_tdata_i;
  assign s_axis_tready_o = (phase_q != PH_MATCH);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = match.done && (!out_valid_q || m_axis_tready_i);
  assign rx_up           = (rx_b inside {["a":"z"]}) ? (rx_b - 8'd32) : rx_b;
  assign alen_sum        = {1'b0, arg_count_q} + 10'd1;

  acp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_count_q[AW-1:0]),
    .wdata_i (rx_up),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  acp_matcher #(
    .AW (AW)
  ) u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .ack_i        (commit),
    .name_count_i (name_count_q),
    .rdata_i      (rdata),
    .raddr_o      (raddr),
    .match_o      (match)
  );

  always_comb begin
    phase_d       = phase_q;
    name_count_d  = name_count_q;
    name_closed_d = name_closed_q;
    arg_count_d   = arg_count_q;
    arg_second_d  = arg_second_q;
    logged_in_d   = logged_in_q;
    pass_stage_d  = pass_stage_q;
    pass_found_d  = pass_found_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    status_d      = status_q;
    command_d     = command_q;
    region_d      = region_q;
    alen_d        = alen_q;
    start         = 1'b0;
    name_we       = 1'b0;

    if (s_acc) begin
      case (phase_q)
        PH_WAIT_A: begin
          if (rx_b == "A" || rx_b == "a") begin
            phase_d = PH_WAIT_T;
          end
        end
        PH_WAIT_T: begin
          if (rx_b == "T" || rx_b == "t") begin
            phase_d = PH_WAIT_PLUS;
          end
        end
        PH_WAIT_PLUS: begin
          if (rx_b == "+") begin
            phase_d       = PH_GATHER;
            name_count_d  = '0;
            name_closed_d = 1'b0;
            arg_count_d   = '0;
            arg_second_d  = '0;
            pass_stage_d  = '0;
            pass_found_d  = 1'b0;
          end
        end
        PH_GATHER: begin
          if (rx_b == 8'h0d || rx_b == 8'h0a) begin
            phase_d = PH_MATCH;
            start   = 1'b1;
          end else if (name_closed_q || rx_b == "," || rx_b == "=" || rx_b == "?") begin
            name_closed_d = 1'b1;
            if ({1'b0, arg_count_q} < 10'(ARG_CAP)) begin
              if (arg_count_q == 9'd1) begin
                arg_second_d = rx_b;
              end
              if (!pass_found_q && ({1'b0, pass_stage_q} < 5'(PASS_LEN))) begin
                if (rx_b == pass_char(pass_stage_q)) begin
                  if ({1'b0, pass_stage_q} == 5'(PASS_LEN - 1)) begin
                    pass_found_d = 1'b1;
                  end else begin
                    pass_stage_d = pass_stage_q + 4'd1;
                  end
                end else begin
                  pass_stage_d = '0;
                end
              end
              arg_count_d = arg_count_q + 9'd1;
            end
          end else begin
            name_we = ({1'b0, name_count_q} < 6'(NAME_MAX));
            if (name_count_q < 5'(NAME_CNT_SAT)) begin
              name_count_d = name_count_q + 5'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (phase_q == PH_MATCH && commit) begin
      phase_d     = PH_WAIT_A;
      out_valid_d = 1'b1;
      status_d    = ST_UNSUPPORTED;
      command_d   = CMD_ERASE;
      region_d    = RG_NONE;
      alen_d      = alen_sum[ARG_W] ? '1 : alen_sum[ARG_W-1:0];
      if (match.hit) begin
        command_d = match.cmd;
        if (cmd_needs_login(match.cmd) && !logged_in_q) begin
          status_d = ST_LOGIN_REQ;
        end else if (match.cmd == CMD_LOGIN) begin
          logged_in_d = pass_found_q;
          status_d    = pass_found_q ? ST_OK : ST_FAIL;
        end else begin
          status_d = ST_OK;
          if (match.cmd == CMD_ERASE) begin
            region_d = (arg_count_q >= 9'd2) ? region_of(arg_second_q) : RG_ALL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT_A;
      name_count_q  <= '0;
      name_closed_q <= 1'b0;
      arg_count_q   <= '0;
      arg_second_q  <= '0;
      logged_in_q   <= 1'b0;
      pass_stage_q  <= '0;
      pass_found_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      name_count_q  <= name_count_d;
      name_closed_q <= name_closed_d;
      arg_count_q   <= arg_count_d;
      arg_second_q  <= arg_second_d;
      logged_in_q   <= logged_in_d;
      pass_stage_q  <= pass_stage_d;
      pass_found_q  <= pass_found_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    command_q <= command_d;
    region_q  <= region_d;
    alen_q    <= alen_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, alen_q, logged_in_q, region_q, command_q, status_q};

  a_match_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match.done |-> !s_axis_tready_o)
    else $error("matcher result pending while input is open");

  a_login_req_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_LOGIN_REQ) |->
      (command_q == CMD_ERASE || command_q == CMD_WRITE || command_q == CMD_UPDATE))
    else $error("login required reported for a command without that need");

  a_region_only_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && region_q != RG_NONE) |-> (command_q == CMD_ERASE && status_q == ST_OK))
    else $error("erase region reported outside an executed erase");

  a_start_from_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (phase_q == PH_MATCH))
    else $error("match started without entering the match phase");

endmodule

[test/tb_at_command_line_parser.sv]
// Self-checking testbench for the AT command line parser: byte stimulus and result scoreboard.
module tb_at_command_line_parser;
  import acp_pkg::*;

  localparam int unsigned NAME_MAX = 16;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef enum logic [1:0] {
    PH_WAIT_A,
    PH_WAIT_T,
    PH_WAIT_PLUS,
    PH_NAME
  } phase_e;

  typedef struct {
    status_e    status;
    cmd_e       cmd;
    region_e    region;
    logic       login;
    logic [8:0] alen;
  } line_result_t;

  class at_line_scoreboard;
    string        cmd_text [8] = '{"ERASE", "WRITE", "UPDATE", "RST", "LOGIN",
                                   {"START_", "APP"}, {"START_", "BOOT"}, "CRC"};
    string        pass_text = {"=\"ee", "X", "cloud\""};
    phase_e       phase = PH_WAIT_A;
    logic [7:0]   name_chars [NAME_MAX];
    int           name_count = 0;
    bit           closed = 0;
    int           arg_count = 0;
    logic [7:0]   arg_second = 8'h00;
    bit           logged_in = 0;
    int           pass_stage = 0;
    bit           pass_found = 0;
    line_result_t line_q [$];
    int           errors = 0;

    function int pending();
      return line_q.size();
    endfunction

    function void take_arg(logic [7:0] b);
      if (arg_count >= ARG_CAP) return;
      if (arg_count == 1) arg_second = b;
      if (!pass_found && pass_stage < PASS_LEN) begin
        if (b == pass_text[pass_stage]) begin
          if (pass_stage + 1 == PASS_LEN) pass_found = 1;
          else pass_stage++;
        end else begin
          pass_stage = 0;
        end
      end
      arg_count++;
    endfunction

    function bit name_is(int k);
      if (name_count != cmd_text[k].len() || name_count > NAME_MAX) return 0;
      for (int i = 0; i < name_count; i++)
        if (name_chars[i] != cmd_text[k][i]) return 0;
      return 1;
    endfunction

    function region_e zone_of(logic [7:0] c);
      if (c == "A" || c == "a") return RG_APP;
      if (c == "S" || c == "s") return RG_SWAP;
      if (c == "D" || c == "d") return RG_DATA;
      return RG_NONE;
    endfunction

    function void finish_line();
      line_result_t r;
      int           hit;
      hit = -1;
      r.status = ST_UNSUPPORTED;
      r.cmd = CMD_ERASE;
      r.region = RG_NONE;
      r.alen = (arg_count + 1 > 511) ? 9'd511 : 9'(arg_count + 1);
      phase = PH_WAIT_A;
      for (int k = 0; k < 8; k++)
        if (hit < 0 && name_is(k)) hit = k;
      if (hit >= 0) begin
        r.cmd = cmd_e'(hit);
        if ((r.cmd == CMD_ERASE || r.cmd == CMD_WRITE || r.cmd == CMD_UPDATE) && !logged_in) begin
          r.status = ST_LOGIN_REQ;
        end else if (r.cmd == CMD_LOGIN) begin
          logged_in = pass_found;
          r.status = pass_found ? ST_OK : ST_FAIL;
        end else begin
          r.status = ST_OK;
          if (r.cmd == CMD_ERASE) r.region = (arg_count >= 2) ? zone_of(arg_second) : RG_ALL;
        end
      end
      r.login = logged_in;
      line_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] u;
      case (phase)
        PH_WAIT_A: begin
          if (b == "A" || b == "a") phase = PH_WAIT_T;
        end
        PH_WAIT_T: begin
          if (b == "T" || b == "t") phase = PH_WAIT_PLUS;
        end
        PH_WAIT_PLUS: begin
          if (b == "+") begin
            phase = PH_NAME;
            name_count = 0;
            closed = 0;
            arg_count = 0;
            arg_second = 8'h00;
            pass_stage = 0;
            pass_found = 0;
          end
        end
        default: begin
          if (b == CH_CR || b == CH_LF) begin
            finish_line();
          end else if (closed) begin
            take_arg(b);
          end else if (b == "," || b == "=" || b == "?") begin
            closed = 1;
            take_arg(b);
          end else begin
            u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
            if (name_count < NAME_MAX) name_chars[name_count] = u;
            if (name_count < NAME_CNT_SAT) name_count++;
          end
        end
      endcase
    endfunction

    function void check_word(logic [23:0] w);
      line_result_t e;
      if (line_q.size() == 0) begin
        $error("result word %h with no line pending", w);
        errors++;
        return;
      end
      e = line_q.pop_front();
      if (w[1:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, w[1:0]);
        errors++;
      end
      if (w[4:2] !== e.cmd) begin
        $error("command: expected %0d, got %0d", e.cmd, w[4:2]);
        errors++;
      end
      if (w[7:5] !== e.region) begin
        $error("erase_region: expected %0d, got %0d", e.region, w[7:5]);
        errors++;
      end
      if (w[8] !== e.login) begin
        $error("login_state: expected %0d, got %0d", e.login, w[8]);
        errors++;
      end
      if (w[17:9] !== e.alen) begin
        $error("arg_length: expected %0d, got %0d", e.alen, w[17:9]);
        errors++;
      end
      if (w[23:18] !== 6'd0) begin
        $error("pad: expected 0, got %0d", w[23:18]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  at_line_scoreboard sb;
  int  sent_count = 0;
  bit  steady = 0;
  bit  hold_go = 0;
  bit  hold_done = 0;

  at_command_line_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #10 clk = ~clk;

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // receiver: random stalls, one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_line(string s, logic [7:0] eol);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(eol);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r == 52) return "_";
    if (r < 26) return 8'("A" + r);
    return 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_arg();
    logic [7:0] c;
    c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
    if (c == CH_CR || c == CH_LF) c = ".";
    return c;
  endfunction

  task automatic send_cmd(int k);
    logic [7:0] c;
    for (int i = 0; i < sb.cmd_text[k].len(); i++) begin
      c = sb.cmd_text[k][i];
      if (c >= "A" && c <= "Z" && $urandom_range(3) == 0) c = c + 8'd32;
      send_byte(c);
    end
  endtask

  task automatic random_line(int idx);
    string      zones;
    int         pick;
    int         k;
    int         bad;
    logic [7:0] c;
    zones = "AaSsDdxQ";
    k = -1;
    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
    send_byte($urandom_range(1) ? "A" : "a");
    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(32, 126)));
    send_byte($urandom_range(1) ? "T" : "t");
    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(32, 126)));
    send_byte("+");
    pick = $urandom_range(99);
    if (pick < 70) begin
      k = $urandom_range(7);
      send_cmd(k);
    end else if (pick < 85) begin
      repeat ($urandom_range(6)) send_byte(rand_letter());
    end else if (pick < 95) begin
      repeat ($urandom_range(11, 25)) send_byte(rand_letter());
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(rand_arg());
    end
    if (idx == 2) begin
      send_byte("=");
      repeat ($urandom_range(511, 525)) send_byte(rand_arg());
    end else if (k == int'(CMD_LOGIN) && $urandom_range(1)) begin
      bad = ($urandom_range(3) == 0) ? $urandom_range(PASS_LEN - 1) : -1;
      for (int i = 0; i < PASS_LEN; i++) begin
        c = sb.pass_text[i];
        send_byte((i == bad) ? 8'(c ^ 8'h20) : c);
      end
      repeat ($urandom_range(2)) send_byte(rand_arg());
    end else if ($urandom_range(9) >= 3) begin
      case ($urandom_range(2))
        0:       send_byte(",");
        1:       send_byte("=");
        default: send_byte("?");
      endcase
      if (k == int'(CMD_ERASE) && $urandom_range(1)) send_byte(zones[$urandom_range(7)]);
      repeat ($urandom_range(6)) send_byte(rand_arg());
    end
    send_byte($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  initial begin
    int start;
    int idx;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines
    send_byte(8'h00);
    send_byte(8'hff);
    send_line("AT+ERASE", CH_CR);
    send_line("xAzT?+WRITE=1", CH_LF);
    send_line("at+update", CH_CR);
    send_line("AT+LOGIN=bad", CH_CR);
    send_line({"AT+LOGIN=\"", sb.pass_text}, CH_CR);
    send_line({"AT+login", sb.pass_text}, CH_LF);
    send_line("AT+ERASE", CH_CR);
    send_line("AT+ERASE=a", CH_CR);
    send_line("AT+Erase,S", CH_LF);
    send_line("AT+ERASE?d", CH_CR);
    send_line("AT+ERASE=q", CH_CR);
    send_line("AT+ERASE=", CH_CR);
    send_line("AT+WRITE=12", CH_CR);
    send_line("AT+UPDATE", CH_CR);
    send_line("AT+RST", CH_LF);
    send_line({"AT+", sb.cmd_text[5]}, CH_CR);
    send_line({"AT+", sb.cmd_text[6].tolower()}, CH_LF);
    send_line("AT+CRC?", CH_CR);
    send_line("AT+FOO", CH_CR);
    send_line("AT+", CH_CR);
    send_line("AT+ABCDEFGHIJKLMNOPQRST", CH_CR);
    send_line({"AT+", sb.cmd_text[6], "XXXXXX"}, CH_LF);

    // random traffic
    start = sent_count;
    idx = 0;
    hold_go = 1;
    while (sent_count < start + 560) begin
      steady = (idx == 2);
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else begin
        random_line(idx);
        idx++;
      end
    end
    steady = 0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
